### hdl/assert_macros.svh
// Assertion helper macros shared by the RTL files.
// Included by modules that carry concurrent checks; needs nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is high.
`define LPR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define LPR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/lpr_pkg.sv
// Shared constants and types for the LFU page replacement block.
// No dependencies; used by the interfaces, lpr_select and lfu_page_replacement.
`timescale 1ns / 1ps

package lpr_pkg;

   localparam int FRAMES_DEF    = 4;
   localparam int PAGE_BITS_DEF = 16;

   localparam int PAGE_PORT_W = 16;
   localparam int SLOT_W      = 2;
   localparam int COUNT_W     = 16;
   localparam int STAMP_W     = 32;
   localparam int FAULT_W     = 32;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Per-frame verdict of the scan compare
   typedef struct packed {
      logic match;   // valid frame holds the referenced page
      logic empty;   // frame is free
      logic better;  // frame beats the current victim candidate
   } scan_flags_type;

endpackage

### hdl/lpr_if.sv
// Valid/ready channel interfaces for page references and replacement results.
// Depends on lpr_pkg for the field widths.
`timescale 1ns / 1ps

interface lpr_req_if;
   logic                               valid;
   logic                               ready;
   logic [lpr_pkg::PAGE_PORT_W-1:0]    page;

   modport source (output valid, output page, input ready);
   modport sink   (input valid, input page, output ready);
endinterface

interface lpr_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               hit;
   logic [lpr_pkg::SLOT_W-1:0]         slot;
   logic                               evicted_valid;
   logic [lpr_pkg::PAGE_PORT_W-1:0]    evicted_page;
   logic [lpr_pkg::FAULT_W-1:0]        fault_total;

   modport source (output valid, output hit, output slot, output evicted_valid,
                   output evicted_page, output fault_total, input ready);
   modport sink   (input valid, input hit, input slot, input evicted_valid,
                   input evicted_page, input fault_total, output ready);
endinterface

### hdl/lpr_frame_mem.sv
// Frame table storage: one write port, one read port, registered read data.
// No package dependencies.
`timescale 1ns / 1ps

module lpr_frame_mem #(
   parameter int DEPTH  = 4,
   parameter int ADDR_W = 2,
   parameter int WIDTH  = 64
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/lpr_select.sv
// Per-frame compare for the scan: tag match, free frame, victim ordering.
// Depends on lpr_pkg for the count/stamp widths and the flag struct.
`timescale 1ns / 1ps

module lpr_select #(
   parameter int PAGE_BITS = lpr_pkg::PAGE_BITS_DEF
) (
   input  logic [PAGE_BITS-1:0]          ref_page,
   input  logic                          row_valid,
   input  logic                          row_first,
   input  logic [PAGE_BITS-1:0]          row_page,
   input  logic [lpr_pkg::COUNT_W-1:0]   row_count,
   input  logic [lpr_pkg::STAMP_W-1:0]   row_stamp,
   input  logic [lpr_pkg::COUNT_W-1:0]   best_count,
   input  logic [lpr_pkg::STAMP_W-1:0]   best_stamp,
   output lpr_pkg::scan_flags_type       flags
);

   logic older;

   // Lower count wins; equal counts go to the earlier arrival, full ties keep the lower index
   assign older = (row_count < best_count) ||
                  ((row_count == best_count) && (row_stamp < best_stamp));

   always_comb begin
      flags.match  = row_valid && (row_page == ref_page);
      flags.empty  = !row_valid;
      flags.better = row_valid && (row_first || older);
   end

endmodule

### hdl/lfu_page_replacement.sv
// LFU page replacement with FIFO tie-break. Each request beat is one page reference and
// yields exactly one response beat: hit flag, frame slot, the evicted page if any and the
// running fault total. Frame contents (page, use count, arrival stamp) live in a synchronous
// memory with one read and one write port that is scanned one frame per cycle. A reference
// is accepted only while idle, and acceptance issues the read of frame 0; the scan then
// compares every frame in turn, and a finish step writes back the frame and loads the response
// register, after which the block is idle again. A waiting response does not block the next
// reference; only the write-back waits for it to drain.
// Frame valid bits are flip-flops cleared by reset, so no clearing pass is needed.
// Depends on lpr_pkg, lpr_if, lpr_frame_mem and lpr_select.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lfu_page_replacement #(
   parameter int FRAMES    = lpr_pkg::FRAMES_DEF,
   parameter int PAGE_BITS = lpr_pkg::PAGE_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   lpr_req_if.sink       req_chan,
   lpr_rsp_if.source     rsp_chan
);

   localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int ROW_W = PAGE_BITS + lpr_pkg::COUNT_W + lpr_pkg::STAMP_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAMES - 1);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_type;

   state_type                        state_ff;
   logic [FRAMES-1:0]                valid_ff;
   logic [lpr_pkg::STAMP_W-1:0]      ref_ff;
   logic [lpr_pkg::FAULT_W-1:0]      fault_ff;
   logic [PAGE_BITS-1:0]             page_ff;
   logic [lpr_pkg::STAMP_W-1:0]      stamp_ff;
   logic [IDX_W-1:0]                 chk_ff;
   logic                             hit_found_ff;
   logic [IDX_W-1:0]                 hit_idx_ff;
   logic [ROW_W-1:0]                 hit_row_ff;
   logic                             empty_found_ff;
   logic [IDX_W-1:0]                 empty_idx_ff;
   logic [IDX_W-1:0]                 best_idx_ff;
   logic [PAGE_BITS-1:0]             best_page_ff;
   logic [lpr_pkg::COUNT_W-1:0]      best_cnt_ff;
   logic [lpr_pkg::STAMP_W-1:0]      best_stamp_ff;

   logic                             rsp_valid_ff;
   logic                             rsp_hit_ff;
   logic [lpr_pkg::SLOT_W-1:0]       rsp_slot_ff;
   logic                             rsp_evicted_valid_ff;
   logic [lpr_pkg::PAGE_PORT_W-1:0]  rsp_evicted_page_ff;
   logic [lpr_pkg::FAULT_W-1:0]      rsp_fault_ff;

   logic                             accept;
   logic                             rsp_free;
   logic                             load;
   logic                             rd_en;
   logic [IDX_W-1:0]                 rd_addr;
   logic [ROW_W-1:0]                 rd_row;
   logic [PAGE_BITS-1:0]             row_page;
   logic [lpr_pkg::COUNT_W-1:0]      row_cnt;
   logic [lpr_pkg::STAMP_W-1:0]      row_stamp;
   logic                             row_valid;
   lpr_pkg::scan_flags_type          flags;

   logic [IDX_W-1:0]                 target;
   logic                             evict;
   logic [lpr_pkg::COUNT_W-1:0]      hit_cnt;
   logic [lpr_pkg::COUNT_W-1:0]      hit_cnt_in;
   logic [ROW_W-1:0]                 wr_row;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign load           = (state_ff == ST_FINISH) && rsp_free;

   // Read frame 0 on accept, then the next frame each scan cycle
   assign rd_en   = accept || ((state_ff == ST_SCAN) && (chk_ff != LAST_IDX));
   assign rd_addr = accept ? '0 : IDX_W'(chk_ff + 1'b1);

   assign {row_page, row_cnt, row_stamp} = rd_row;
   assign row_valid = valid_ff[chk_ff];

   assign evict   = !hit_found_ff && !empty_found_ff;
   assign target  = hit_found_ff ? hit_idx_ff : (empty_found_ff ? empty_idx_ff : best_idx_ff);
   assign hit_cnt = hit_row_ff[lpr_pkg::STAMP_W +: lpr_pkg::COUNT_W];
   assign hit_cnt_in = (hit_cnt == lpr_pkg::COUNT_MAX) ? hit_cnt
                                                       : lpr_pkg::COUNT_W'(hit_cnt + 1'b1);
   assign wr_row  = hit_found_ff
                  ? {page_ff, hit_cnt_in, hit_row_ff[lpr_pkg::STAMP_W-1:0]}
                  : {page_ff, {lpr_pkg::COUNT_W{1'b0}}, stamp_ff};

   lpr_frame_mem #(
      .DEPTH  (FRAMES),
      .ADDR_W (IDX_W),
      .WIDTH  (ROW_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (load),
      .wr_addr (target),
      .wr_data (wr_row),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_row)
   );

   lpr_select #(
      .PAGE_BITS (PAGE_BITS)
   ) u_select (
      .ref_page   (page_ff),
      .row_valid  (row_valid),
      .row_first  (chk_ff == '0),
      .row_page   (row_page),
      .row_count  (row_cnt),
      .row_stamp  (row_stamp),
      .best_count (best_cnt_ff),
      .best_stamp (best_stamp_ff),
      .flags      (flags)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         ref_ff       <= '0;
         fault_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  page_ff        <= PAGE_BITS'(req_chan.page);
                  stamp_ff       <= ref_ff;
                  ref_ff         <= lpr_pkg::STAMP_W'(ref_ff + 1'b1);
                  chk_ff         <= '0;
                  hit_found_ff   <= 1'b0;
                  empty_found_ff <= 1'b0;
                  state_ff       <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (flags.match && !hit_found_ff) begin
                  hit_found_ff <= 1'b1;
                  hit_idx_ff   <= chk_ff;
                  hit_row_ff   <= rd_row;
               end
               if (flags.empty && !empty_found_ff) begin
                  empty_found_ff <= 1'b1;
                  empty_idx_ff   <= chk_ff;
               end
               if (flags.better) begin
                  best_idx_ff   <= chk_ff;
                  best_page_ff  <= row_page;
                  best_cnt_ff   <= row_cnt;
                  best_stamp_ff <= row_stamp;
               end
               chk_ff <= IDX_W'(chk_ff + 1'b1);
               if (chk_ff == LAST_IDX) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               // Hold the write-back until the response register is free
               if (rsp_free) begin
                  if (!hit_found_ff) begin
                     valid_ff[target] <= 1'b1;
                     fault_ff         <= lpr_pkg::FAULT_W'(fault_ff + 1'b1);
                     rsp_fault_ff     <= lpr_pkg::FAULT_W'(fault_ff + 1'b1);
                  end else begin
                     rsp_fault_ff     <= fault_ff;
                  end
                  rsp_hit_ff           <= hit_found_ff;
                  rsp_slot_ff          <= lpr_pkg::SLOT_W'(target);
                  rsp_evicted_valid_ff <= evict;
                  rsp_evicted_page_ff  <= evict ? lpr_pkg::PAGE_PORT_W'(best_page_ff) : '0;
                  state_ff             <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.hit           = rsp_hit_ff;
   assign rsp_chan.slot          = rsp_slot_ff;
   assign rsp_chan.evicted_valid = rsp_evicted_valid_ff;
   assign rsp_chan.evicted_page  = rsp_evicted_page_ff;
   assign rsp_chan.fault_total   = rsp_fault_ff;

   `LPR_ASSERT(a_hit_no_evict, clock, reset,
               rsp_valid_ff && rsp_hit_ff |-> !rsp_evicted_valid_ff,
               "hit beat reports an eviction")
   `LPR_ASSERT(a_evict_full, clock, reset,
               load && evict |-> (&valid_ff),
               "eviction while a frame is free")
   `LPR_ASSERT(a_fault_step, clock, reset,
               load && !hit_found_ff |=> fault_ff == $past(fault_ff) + 1'b1,
               "fault count did not advance on a miss")
   `LPR_ASSERT(a_valid_sticky, clock, reset,
               !$past(reset) |-> (valid_ff & $past(valid_ff)) == $past(valid_ff),
               "frame valid bit dropped")
   `LPR_ASSERT(a_no_accept_busy, clock, reset,
               state_ff != ST_IDLE |-> !accept,
               "reference accepted during a scan")

endmodule
